>>> design/dtt_pkg.sv
// Shared constants, codes and handshake types for the divider/counter timer.
`default_nettype none

package dtt_pkg;

  // Prescaler width; every period below must fit in it.
  localparam int unsigned PRE_W  = 13;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CTRL_W = 3;

  localparam logic [PRE_W-1:0] DIV_PERIOD  = PRE_W'(256);
  localparam logic [PRE_W-1:0] PERIOD_SEL0 = PRE_W'(1024);
  localparam logic [PRE_W-1:0] PERIOD_SEL1 = PRE_W'(16);
  localparam logic [PRE_W-1:0] PERIOD_SEL2 = PRE_W'(64);
  localparam logic [PRE_W-1:0] PERIOD_SEL3 = PRE_W'(256);

  // Control register layout.
  localparam int unsigned CTRL_EN_BIT = 2;

  localparam logic [BYTE_W-1:0] CNT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_DIV  = 2'd0,
    REG_CNT  = 2'd1,
    REG_MOD  = 2'd2,
    REG_CTRL = 2'd3
  } reg_e;

  // Controller -> datapath.
  typedef struct packed {
    logic exec;     // apply the accepted word
    logic step;     // one prescaler step for each due unit
    logic publish;  // copy result into the output register
  } cmd_t;

  // Datapath -> controller.
  typedef struct packed {
    logic div_due;
    logic cnt_due;
  } sts_t;

  function automatic logic [PRE_W-1:0] sel_period(input logic [1:0] sel);
    logic [PRE_W-1:0] p;
    case (sel)
      2'd0:    p = PERIOD_SEL0;
      2'd1:    p = PERIOD_SEL1;
      2'd2:    p = PERIOD_SEL2;
      default: p = PERIOD_SEL3;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> design/dtt_datapath.sv
// Timer registers, prescalers, result and output registers.
`default_nettype none

module dtt_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dtt_pkg::cmd_t               cmd_i,
  output dtt_pkg::sts_t                    sts_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic [1:0]                  reg_sel_i,
  input  wire logic [dtt_pkg::BYTE_W-1:0]  write_data_i,
  input  wire logic [dtt_pkg::BYTE_W-1:0]  tick_cycles_i,
  output logic      [dtt_pkg::BYTE_W-1:0]  read_data_o,
  output logic                             timer_irq_o
);

  logic [dtt_pkg::PRE_W-1:0]  div_pre_q, div_pre_d;
  logic [dtt_pkg::BYTE_W-1:0] div_q, div_d;
  logic [dtt_pkg::PRE_W-1:0]  cnt_pre_q, cnt_pre_d;
  logic [dtt_pkg::BYTE_W-1:0] cnt_q, cnt_d;
  logic [dtt_pkg::BYTE_W-1:0] mod_q, mod_d;
  logic [dtt_pkg::CTRL_W-1:0] ctrl_q, ctrl_d;
  logic [dtt_pkg::BYTE_W-1:0] res_rd_q, res_rd_d;
  logic                       res_irq_q, res_irq_d;
  logic [dtt_pkg::BYTE_W-1:0] out_rd_q;
  logic                       out_irq_q;

  logic [dtt_pkg::PRE_W-1:0]  period;
  logic                       cnt_en;

  assign period = dtt_pkg::sel_period(ctrl_q[1:0]);
  assign cnt_en = ctrl_q[dtt_pkg::CTRL_EN_BIT];

  assign sts_o.div_due = (div_pre_q >= dtt_pkg::DIV_PERIOD);
  assign sts_o.cnt_due = cnt_en && (cnt_pre_q >= period);

  always_comb begin
    div_pre_d = div_pre_q;
    div_d     = div_q;
    cnt_pre_d = cnt_pre_q;
    cnt_d     = cnt_q;
    mod_d     = mod_q;
    ctrl_d    = ctrl_q;
    res_rd_d  = res_rd_q;
    res_irq_d = res_irq_q;

    if (cmd_i.exec) begin
      res_rd_d  = '0;
      res_irq_d = 1'b0;
      case (op_i)
        dtt_pkg::OP_TICK: begin
          // 13-bit wrap matches the prescaler mask
          div_pre_d = div_pre_q + dtt_pkg::PRE_W'(tick_cycles_i);
          if (cnt_en) begin
            cnt_pre_d = cnt_pre_q + dtt_pkg::PRE_W'(tick_cycles_i);
          end
        end
        dtt_pkg::OP_READ: begin
          case (reg_sel_i)
            dtt_pkg::REG_DIV: res_rd_d = div_q;
            dtt_pkg::REG_CNT: res_rd_d = cnt_q;
            dtt_pkg::REG_MOD: res_rd_d = mod_q;
            default:          res_rd_d = dtt_pkg::BYTE_W'(ctrl_q);
          endcase
        end
        dtt_pkg::OP_WRITE: begin
          case (reg_sel_i)
            dtt_pkg::REG_DIV: begin
              div_d     = '0;
              div_pre_d = '0;
            end
            dtt_pkg::REG_CNT: cnt_d = write_data_i;
            dtt_pkg::REG_MOD: mod_d = write_data_i;
            default: begin
              ctrl_d    = write_data_i[dtt_pkg::CTRL_W-1:0];
              cnt_pre_d = '0;
            end
          endcase
        end
        default: ;
      endcase
    end else if (cmd_i.step) begin
      if (sts_o.div_due) begin
        div_pre_d = div_pre_q - dtt_pkg::DIV_PERIOD;
        div_d     = div_q + 1'b1;
      end
      if (sts_o.cnt_due) begin
        cnt_pre_d = cnt_pre_q - period;
        if (cnt_q == dtt_pkg::CNT_MAX) begin
          cnt_d     = mod_q;
          res_irq_d = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_pre_q <= '0;
      div_q     <= '0;
      cnt_pre_q <= '0;
      cnt_q     <= '0;
      mod_q     <= '0;
      ctrl_q    <= '0;
    end else begin
      div_pre_q <= div_pre_d;
      div_q     <= div_d;
      cnt_pre_q <= cnt_pre_d;
      cnt_q     <= cnt_d;
      mod_q     <= mod_d;
      ctrl_q    <= ctrl_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    res_rd_q  <= res_rd_d;
    res_irq_q <= res_irq_d;
    if (cmd_i.publish) begin
      out_rd_q  <= res_rd_q;
      out_irq_q <= res_irq_q;
    end
  end

  assign read_data_o = out_rd_q;
  assign timer_irq_o = out_irq_q;

endmodule

`default_nettype wire

>>> design/dtt_ctrl.sv
// Sequencer: accepts a word, runs prescaler steps, hands the result to the output.
`default_nettype none

module dtt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire dtt_pkg::sts_t sts_i,
  output dtt_pkg::cmd_t      cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_STEP
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   due;
  logic   slot_free;

  assign due       = sts_i.div_due || sts_i.cnt_due;
  assign slot_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_o.exec    = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.step    = (state_q == ST_STEP) && due;
  assign cmd_o.publish = (state_q == ST_STEP) && !due && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.publish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (cmd_o.publish) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Prescalers are always below their period between words.
  a_idle_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !sts_i.div_due && !sts_i.cnt_due)
    else $error("prescaler left at or above its period");

  a_publish_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> !cmd_o.step && !cmd_o.exec)
    else $error("result published while work remains");

  a_accept_to_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_STEP && !in_stall_o == 1'b0)
    else $error("accepted word not processed");

  a_out_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_STEP))
    else $error("output raised outside result hand-off");

endmodule

`default_nettype wire

>>> design/div_tima_prescaled_timer_unit.sv
// A word is accepted in idle; its k prescaler steps then run one per cycle, and the result
// is published to the output register once that is free. k = prescaler steps of a tick,
// 0 otherwise: the larger of divider and counter steps (at most 16 with defaults).
// The output register frees the input side while a result waits to be taken.
// Reset (async, active low) clears all timer registers, prescalers and valid flags.
`default_nettype none

module div_tima_prescaled_timer_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic [1:0]                  reg_sel_i,
  input  wire logic [dtt_pkg::BYTE_W-1:0]  write_data_i,
  input  wire logic [dtt_pkg::BYTE_W-1:0]  tick_cycles_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [dtt_pkg::BYTE_W-1:0]  read_data_o,
  output logic                             timer_irq_o
);

  dtt_pkg::cmd_t cmd;
  dtt_pkg::sts_t sts;

  dtt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dtt_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op_i),
    .reg_sel_i     (reg_sel_i),
    .write_data_i  (write_data_i),
    .tick_cycles_i (tick_cycles_i),
    .read_data_o   (read_data_o),
    .timer_irq_o   (timer_irq_o)
  );

endmodule

`default_nettype wire
